>>> rtl/core/bbms_pkg.sv
// Shared constants, codes and handshake types of the buzzer tone sequencer.
package bbms_pkg;

  localparam int unsigned NOTE_DEPTH   = 256;
  localparam int unsigned MS_PER_WHOLE = 1000;

  localparam int unsigned OP_W       = 3;
  localparam int unsigned NOW_W      = 32;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned FREQ_W     = 16;
  localparam int unsigned DIVN_W     = 8;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned MS_W       = 16;
  localparam int unsigned LEN_W      = 9;
  localparam int unsigned PHASE_W    = 9;
  localparam int unsigned POS_W      = 9;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned QUO_W      = 16;
  localparam int unsigned NOTE_AW    = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;
  localparam int unsigned NOTE_RAM_W = FREQ_W + DIVN_W;

  localparam logic [QUO_W-1:0] WHOLE_MS = QUO_W'(MS_PER_WHOLE);

  localparam logic [OP_W-1:0] OP_TICK        = 3'd0;
  localparam logic [OP_W-1:0] OP_START_BEEPS = 3'd1;
  localparam logic [OP_W-1:0] OP_START_MEL   = 3'd2;
  localparam logic [OP_W-1:0] OP_STOP        = 3'd3;
  localparam logic [OP_W-1:0] OP_LOAD_NOTE   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_BEEP_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BEEP_FREQ  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BEEP_ON    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BEEP_GAP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MEL_LEN    = 3'd4;

  typedef struct packed {
    logic              start;
    logic [DIVN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> rtl/core/bbms_ram.sv
// Generic single-port-write, registered-read RAM.
module bbms_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/bbms_div.sv
// Iterative restoring divider: whole-note length divided by the note division.
module bbms_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bbms_pkg::div_req_t  req_i,
  output bbms_pkg::div_rsp_t  rsp_o
);
  import bbms_pkg::*;

  localparam int unsigned STEP_W = $clog2(QUO_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DIVN_W-1:0] dvs_q, dvs_d;
  logic [DIVN_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [DIVN_W:0]   trial;
  logic              fits;

  // one quotient bit per cycle
  assign trial = {rem_q, quo_q[QUO_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = STEP_W'(QUO_W);
      dvs_d  = req_i.divisor;
      rem_d  = '0;
      quo_d  = WHOLE_MS;
    end else if (busy_q) begin
      rem_d  = fits ? DIVN_W'(trial - {1'b0, dvs_q}) : trial[DIVN_W-1:0];
      quo_d  = {quo_q[QUO_W-2:0], fits};
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

>>> rtl/core/buzzer_beep_and_melody_sequencer.sv
// Top level: beep burst and melody sequencer driving the buzzer tone.
// Flow: commands, beep ticks and idle ticks go from ST_EXEC to ST_OUT; a melody tick
//   that plays a note passes ST_READ (table read) and ST_DIV (16 divider steps) on the way.
// One transaction at a time: the next one is accepted once the result
//   has entered the output register.
// Reset: rst_ni clears control state, registers and outputs; the note table is not cleared.
module buzzer_beep_and_melody_sequencer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [bbms_pkg::OP_W-1:0]           operation_i,
  input  logic [bbms_pkg::NOW_W-1:0]          now_ms_i,
  input  logic [bbms_pkg::IDX_W-1:0]          note_index_i,
  input  logic [bbms_pkg::FREQ_W-1:0]         note_freq_i,
  input  logic [bbms_pkg::DIVN_W-1:0]         note_division_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                tone_on_o,
  output logic [bbms_pkg::FREQ_W-1:0]         tone_freq_o,
  output logic                                beeping_o,
  output logic                                melody_playing_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bbms_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bbms_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import bbms_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_READ = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] state_q, state_d;

  // configuration
  logic [CNT_W-1:0]  beep_count_q;
  logic [FREQ_W-1:0] beep_freq_q;
  logic [MS_W-1:0]   beep_on_q;
  logic [MS_W-1:0]   beep_gap_q;
  logic [LEN_W-1:0]  mel_len_q;

  // latched transaction
  logic [OP_W-1:0]   op_q;
  logic [NOW_W-1:0]  now_q;
  logic [IDX_W-1:0]  idx_q;
  logic [FREQ_W-1:0] nf_q;
  logic [DIVN_W-1:0] nd_q;

  // sequencer state
  logic               beep_act_q, beep_act_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [NOW_W-1:0]   beep_dl_q, beep_dl_d;
  logic               mel_act_q, mel_act_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [NOW_W-1:0]   note_dl_q, note_dl_d;
  logic               snd_q, snd_d;
  logic [FREQ_W-1:0]  sfreq_q, sfreq_d;
  logic [FREQ_W-1:0]  note_f_q, note_f_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic              out_tone_q;
  logic [FREQ_W-1:0] out_freq_q;
  logic              out_beep_q;
  logic              out_mel_q;
  logic              out_load;

  logic                  in_accept;
  logic [NOW_W-1:0]      dl_sel, diff, add_op, sum;
  logic                  due;
  logic [NOW_W-1:0]      idx_w, pos_w;
  logic                  idx_ok, pos_ok;
  logic                  ram_we, ram_re;
  logic [NOTE_RAM_W-1:0] ram_rdata;
  logic [DIVN_W-1:0]     rd_div;
  div_req_t              div_req;
  div_rsp_t              div_rsp;

  assign in_stall_o  = state_q != ST_IDLE;
  assign in_accept   = in_valid_i && (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // shared compare and add unit
  assign dl_sel = beep_act_q ? beep_dl_q : note_dl_q;
  assign diff   = now_q - dl_sel;
  assign due    = !diff[NOW_W-1];
  always_comb begin
    if (state_q == ST_DIV) begin
      add_op = NOW_W'(div_rsp.quotient);
    end else if (phase_q[0]) begin
      add_op = NOW_W'(beep_gap_q);
    end else begin
      add_op = NOW_W'(beep_on_q);
    end
  end
  assign sum = now_q + add_op;

  assign idx_w  = NOW_W'(idx_q);
  assign pos_w  = NOW_W'(pos_q);
  assign idx_ok = idx_w < NOW_W'(NOTE_DEPTH);
  assign pos_ok = (pos_q < mel_len_q) && (pos_w < NOW_W'(NOTE_DEPTH));
  assign rd_div = ram_rdata[DIVN_W-1:0];

  always_comb begin
    state_d    = state_q;
    beep_act_d = beep_act_q;
    phase_d    = phase_q;
    beep_dl_d  = beep_dl_q;
    mel_act_d  = mel_act_q;
    pos_d      = pos_q;
    note_dl_d  = note_dl_q;
    snd_d      = snd_q;
    sfreq_d    = sfreq_q;
    note_f_d   = note_f_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    div_req    = '{start: 1'b0, divisor: rd_div};
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_OUT;
        case (op_q)
          OP_START_BEEPS: begin
            phase_d    = '0;
            beep_act_d = 1'b1;
            beep_dl_d  = now_q;
          end
          OP_START_MEL: begin
            pos_d     = '0;
            mel_act_d = 1'b1;
            note_dl_d = now_q;
          end
          OP_STOP: begin
            snd_d      = 1'b0;
            sfreq_d    = '0;
            mel_act_d  = 1'b0;
            beep_act_d = 1'b0;
          end
          OP_LOAD_NOTE: begin
            ram_we = idx_ok;
          end
          default: begin
            if (beep_act_q) begin
              if (due) begin
                if (phase_q < {beep_count_q, 1'b0}) begin
                  snd_d     = !phase_q[0];
                  sfreq_d   = phase_q[0] ? '0 : beep_freq_q;
                  beep_dl_d = sum;
                  phase_d   = phase_q + PHASE_W'(1);
                end else begin
                  snd_d      = 1'b0;
                  sfreq_d    = '0;
                  beep_act_d = 1'b0;
                end
              end
            end else if (mel_act_q && due) begin
              if (pos_ok) begin
                ram_re  = 1'b1;
                state_d = ST_READ;
              end else begin
                snd_d     = 1'b0;
                sfreq_d   = '0;
                mel_act_d = 1'b0;
              end
            end
          end
        endcase
      end
      ST_READ: begin
        // a division of zero plays as one
        note_f_d        = ram_rdata[NOTE_RAM_W-1:DIVN_W];
        div_req.start   = 1'b1;
        div_req.divisor = (rd_div == '0) ? DIVN_W'(1) : rd_div;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          snd_d     = note_f_q != '0;
          sfreq_d   = note_f_q;
          note_dl_d = sum;
          pos_d     = pos_q + POS_W'(1);
          state_d   = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      beep_act_q   <= 1'b0;
      phase_q      <= '0;
      beep_dl_q    <= '0;
      mel_act_q    <= 1'b0;
      pos_q        <= '0;
      note_dl_q    <= '0;
      snd_q        <= 1'b0;
      sfreq_q      <= '0;
      out_valid_q  <= 1'b0;
      out_tone_q   <= 1'b0;
      out_freq_q   <= '0;
      out_beep_q   <= 1'b0;
      out_mel_q    <= 1'b0;
      beep_count_q <= '0;
      beep_freq_q  <= '0;
      beep_on_q    <= '0;
      beep_gap_q   <= '0;
      mel_len_q    <= '0;
    end else begin
      state_q     <= state_d;
      beep_act_q  <= beep_act_d;
      phase_q     <= phase_d;
      beep_dl_q   <= beep_dl_d;
      mel_act_q   <= mel_act_d;
      pos_q       <= pos_d;
      note_dl_q   <= note_dl_d;
      snd_q       <= snd_d;
      sfreq_q     <= sfreq_d;
      out_valid_q <= out_valid_d;
      if (out_load) begin
        out_tone_q <= snd_q;
        out_freq_q <= snd_q ? sfreq_q : '0;
        out_beep_q <= beep_act_q;
        out_mel_q  <= mel_act_q;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_BEEP_COUNT: beep_count_q <= cfg_data_i[CNT_W-1:0];
          REG_BEEP_FREQ:  beep_freq_q  <= cfg_data_i[FREQ_W-1:0];
          REG_BEEP_ON:    beep_on_q    <= cfg_data_i[MS_W-1:0];
          REG_BEEP_GAP:   beep_gap_q   <= cfg_data_i[MS_W-1:0];
          REG_MEL_LEN:    mel_len_q    <= cfg_data_i[LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    note_f_q <= note_f_d;
    if (in_accept) begin
      op_q  <= operation_i;
      now_q <= now_ms_i;
      idx_q <= note_index_i;
      nf_q  <= note_freq_i;
      nd_q  <= note_division_i;
    end
  end

  bbms_ram #(
    .Width (NOTE_RAM_W),
    .Depth (NOTE_DEPTH)
  ) u_note_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_w[NOTE_AW-1:0]),
    .wdata_i ({nf_q, nd_q}),
    .re_i    (ram_re),
    .raddr_i (pos_w[NOTE_AW-1:0]),
    .rdata_o (ram_rdata)
  );

  bbms_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_valid_o      = out_valid_q;
  assign tone_on_o        = out_tone_q;
  assign tone_freq_o      = out_freq_q;
  assign beeping_o        = out_beep_q;
  assign melody_playing_o = out_mel_q;

endmodule

>>> rtl/core/bbms_checker.sv
// Port-level checker for the buzzer tone sequencer, bound to the top level.
module bbms_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic                            tone_on_o,
  input logic [bbms_pkg::FREQ_W-1:0]     tone_freq_o,
  input logic                            beeping_o,
  input logic                            melody_playing_o
);

  logic       in_acc, out_acc;
  logic [1:0] pending_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // track transactions accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 2'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(tone_on_o)
      && $stable(tone_freq_o) && $stable(beeping_o) && $stable(melody_playing_o))
    else $error("stalled result changed");

  a_silent_freq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tone_on_o |-> tone_freq_o == '0)
    else $error("frequency driven while silent");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 2'd0)
    else $error("result without a pending transaction");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q == 2'd2) || (pending_q == 2'd1 && !out_valid_o) |-> in_stall_o)
    else $error("accepting while a transaction is still in work");

endmodule

bind buzzer_beep_and_melody_sequencer bbms_checker u_bbms_checker (.*);

>>> sim/testbench.sv
// Self-checking testbench for the buzzer beep and melody sequencer.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bbms_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 25;
  localparam int QUIET_LIMIT   = 5000;
  localparam int PHASE_ITEMS   = 130;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic              tone_on;
    logic [FREQ_W-1:0] tone_freq;
    logic              beeping;
    logic              melody_playing;
  } tone_state_t;

  class tone_scoreboard;
    logic [CNT_W-1:0]  beep_count;
    logic [FREQ_W-1:0] beep_freq;
    logic [MS_W-1:0]   on_ms;
    logic [MS_W-1:0]   gap_ms;
    logic [LEN_W-1:0]  mel_len;

    bit                burst_on;
    logic [PHASE_W-1:0] phase;
    logic [NOW_W-1:0]  burst_due;
    bit                mel_on;
    logic [POS_W-1:0]  pos;
    logic [NOW_W-1:0]  note_due;
    logic [FREQ_W-1:0] tab_freq [NOTE_DEPTH];
    logic [DIVN_W-1:0] tab_div  [NOTE_DEPTH];
    bit                snd;
    logic [FREQ_W-1:0] snd_freq;

    tone_state_t       expected_tones [$];
    int                failures;

    function new();
      beep_count = '0;
      beep_freq  = '0;
      on_ms      = '0;
      gap_ms     = '0;
      mel_len    = '0;
      burst_on   = 1'b0;
      phase      = '0;
      burst_due  = '0;
      mel_on     = 1'b0;
      pos        = '0;
      note_due   = '0;
      snd        = 1'b0;
      snd_freq   = '0;
      failures   = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_BEEP_COUNT: beep_count = data[CNT_W-1:0];
        REG_BEEP_FREQ:  beep_freq  = data[FREQ_W-1:0];
        REG_BEEP_ON:    on_ms      = data[MS_W-1:0];
        REG_BEEP_GAP:   gap_ms     = data[MS_W-1:0];
        REG_MEL_LEN:    mel_len    = data[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function bit is_due(logic [NOW_W-1:0] now, logic [NOW_W-1:0] deadline);
      logic [NOW_W-1:0] diff;
      diff = now - deadline;
      return !diff[NOW_W-1];
    endfunction

    function void silence();
      snd      = 1'b0;
      snd_freq = '0;
    endfunction

    function void run_tick(logic [NOW_W-1:0] now);
      logic [FREQ_W-1:0] f;
      logic [DIVN_W-1:0] d;
      int unsigned       span;
      if (burst_on) begin
        if (is_due(now, burst_due)) begin
          if (phase < {beep_count, 1'b0}) begin
            if (!phase[0]) begin
              snd       = 1'b1;
              snd_freq  = beep_freq;
              burst_due = now + NOW_W'(on_ms);
            end else begin
              silence();
              burst_due = now + NOW_W'(gap_ms);
            end
            phase = phase + 1'b1;
          end else begin
            silence();
            burst_on = 1'b0;
          end
        end
      end else if (mel_on && is_due(now, note_due)) begin
        if (pos < mel_len && pos < NOTE_DEPTH) begin
          f = tab_freq[pos[NOTE_AW-1:0]];
          d = tab_div[pos[NOTE_AW-1:0]];
          span = (d == '0) ? MS_PER_WHOLE : MS_PER_WHOLE / d;
          if (f != '0) begin
            snd      = 1'b1;
            snd_freq = f;
          end else begin
            silence();
          end
          note_due = now + NOW_W'(span);
          pos      = pos + 1'b1;
        end else begin
          silence();
          mel_on = 1'b0;
        end
      end
    endfunction

    // Advance the predicted state by one accepted transaction and queue its result.
    function void note_item(logic [OP_W-1:0] op, logic [NOW_W-1:0] now,
                            logic [IDX_W-1:0] idx, logic [FREQ_W-1:0] freq,
                            logic [DIVN_W-1:0] divn);
      tone_state_t exp_tone;
      case (op)
        OP_START_BEEPS: begin
          phase     = '0;
          burst_on  = 1'b1;
          burst_due = now;
        end
        OP_START_MEL: begin
          pos      = '0;
          mel_on   = 1'b1;
          note_due = now;
        end
        OP_STOP: begin
          silence();
          mel_on   = 1'b0;
          burst_on = 1'b0;
        end
        OP_LOAD_NOTE: begin
          if (idx < NOTE_DEPTH) begin
            tab_freq[idx] = freq;
            tab_div[idx]  = divn;
          end
        end
        default: run_tick(now);
      endcase
      exp_tone.tone_on        = snd;
      exp_tone.tone_freq      = snd ? snd_freq : '0;
      exp_tone.beeping        = burst_on;
      exp_tone.melody_playing = mel_on;
      expected_tones.push_back(exp_tone);
    endfunction

    function void check_tone(tone_state_t got);
      tone_state_t want;
      if (expected_tones.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("unexpected result: on=%0b freq=%0h beeping=%0b melody=%0b",
                   got.tone_on, got.tone_freq, got.beeping, got.melody_playing);
        return;
      end
      want = expected_tones.pop_front();
      if (got.tone_on !== want.tone_on || got.tone_freq !== want.tone_freq ||
          got.beeping !== want.beeping || got.melody_playing !== want.melody_playing) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("mismatch: expected on=%0b freq=%0h beeping=%0b melody=%0b, ",
                   want.tone_on, want.tone_freq, want.beeping, want.melody_playing,
                   "got on=%0b freq=%0h beeping=%0b melody=%0b",
                   got.tone_on, got.tone_freq, got.beeping, got.melody_playing);
      end
    endfunction

    function int pending();
      return expected_tones.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [OP_W-1:0]       operation_i;
  logic [NOW_W-1:0]      now_ms_i;
  logic [IDX_W-1:0]      note_index_i;
  logic [FREQ_W-1:0]     note_freq_i;
  logic [DIVN_W-1:0]     note_division_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  tone_on_o;
  logic [FREQ_W-1:0]     tone_freq_o;
  logic                  beeping_o;
  logic                  melody_playing_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  tone_scoreboard sb;
  bit             tx_idle = 1'b1;
  bit             rx_idle = 1'b1;
  bit             hold_req = 1'b0;
  bit             written [NOTE_DEPTH];
  int             sent_items = 0;
  int             quiet_cycles = 0;
  logic [NOW_W-1:0] clock_ms;

  buzzer_beep_and_melody_sequencer u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .now_ms_i         (now_ms_i),
    .note_index_i     (note_index_i),
    .note_freq_i      (note_freq_i),
    .note_division_i  (note_division_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .tone_on_o        (tone_on_o),
    .tone_freq_o      (tone_freq_o),
    .beeping_o        (beeping_o),
    .melody_playing_o (melody_playing_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Check the result first, then note the input accepted at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.check_tone('{tone_on_o, tone_freq_o, beeping_o, melody_playing_o});
      if (in_valid_i && !in_stall_o)
        sb.note_item(operation_i, now_ms_i, note_index_i, note_freq_i, note_division_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Result side: random stall before each transaction while rx_idle is set, one long hold-off on request.
  initial begin
    int gap;
    int taken;
    taken = 0;
    out_stall_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        gap = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        gap = rx_idle ? $urandom_range(0, 12) : 0;
      end
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
      if (taken % 64 == 0) rx_idle = ($urandom_range(0, 3) != 0);
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [NOW_W-1:0] now,
                           input logic [IDX_W-1:0] idx, input logic [FREQ_W-1:0] freq,
                           input logic [DIVN_W-1:0] divn);
    int gap;
    gap = tx_idle ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    operation_i     <= op;
    now_ms_i        <= now;
    note_index_i    <= idx;
    note_freq_i     <= freq;
    note_division_i <= divn;
    if (op == OP_LOAD_NOTE) written[idx] = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sent_items++;
    if (sent_items % 48 == 0) tx_idle = ($urandom_range(0, 3) != 0);
  endtask

  // Hold off until every queued result is back and the block has settled.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_registers(input logic [CNT_W-1:0] cnt, input logic [FREQ_W-1:0] bfreq,
                                   input logic [MS_W-1:0] on, input logic [MS_W-1:0] off,
                                   input logic [LEN_W-1:0] len);
    logic [CFG_IDX_W-1:0]  regs [5];
    logic [CFG_DATA_W-1:0] vals [5];
    regs[0] = REG_BEEP_COUNT;  vals[0] = CFG_DATA_W'(cnt);
    regs[1] = REG_BEEP_FREQ;   vals[1] = CFG_DATA_W'(bfreq);
    regs[2] = REG_BEEP_ON;     vals[2] = CFG_DATA_W'(on);
    regs[3] = REG_BEEP_GAP;    vals[3] = CFG_DATA_W'(off);
    regs[4] = REG_MEL_LEN;     vals[4] = CFG_DATA_W'(len);
    for (int i = 0; i < 5; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.set_register(regs[i], vals[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [FREQ_W-1:0] rand_freq();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return FREQ_W'($urandom);
  endfunction

  function automatic logic [DIVN_W-1:0] rand_div();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return DIVN_W'($urandom);
  endfunction

  function automatic logic [NOW_W-1:0] step_ms();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return NOW_W'($urandom_range(0, 3));
    if (r < 75) return NOW_W'($urandom_range(4, 40));
    if (r < 88) return NOW_W'($urandom_range(41, 1200));
    if (r < 97) return NOW_W'($urandom_range(1201, 70000));
    return NOW_W'($urandom);
  endfunction

  // Write every table entry the melody can reach before any tick reads it.
  task automatic load_melody(input int unsigned len);
    for (int i = 0; i < NOTE_DEPTH && i < len; i++)
      if (!written[i]) send_item(OP_LOAD_NOTE, clock_ms, IDX_W'(i), rand_freq(), rand_div());
  endtask

  initial begin
    logic [NOW_W-1:0]  t0;
    logic [OP_W-1:0]   op;
    logic [CNT_W-1:0]  cnt;
    logic [FREQ_W-1:0] bfreq;
    logic [MS_W-1:0]   on;
    logic [MS_W-1:0]   off;
    logic [LEN_W-1:0]  len;
    int unsigned       r;

    sb = new();
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    operation_i     = OP_TICK;
    now_ms_i        = '0;
    note_index_i    = '0;
    note_freq_i     = '0;
    note_division_i = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = REG_BEEP_COUNT;
    cfg_data_i      = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset registers: empty burst and empty melody end on the first due tick.
    send_item(OP_TICK, 32'd0, '0, '0, '0);
    send_item(OP_START_BEEPS, 32'd1, '0, '0, '0);
    send_item(OP_TICK, 32'd1, '0, '0, '0);
    send_item(OP_START_MEL, 32'd2, '0, '0, '0);
    send_item(OP_TICK, 32'd2, '0, '0, '0);
    drain();

    program_registers(8'd2, 16'hFFFF, 16'd5, 16'd3, 9'd4);
    t0 = 32'hFFFF_FFF8;
    send_item(OP_LOAD_NOTE, t0, 8'd0, 16'hFFFF, 8'd0);
    send_item(OP_LOAD_NOTE, t0, 8'd1, 16'h0000, 8'hFF);
    send_item(OP_LOAD_NOTE, t0, 8'd2, 16'h0001, 8'd1);
    send_item(OP_LOAD_NOTE, t0, 8'hFF, 16'h1234, 8'h80);
    send_item(OP_LOAD_NOTE, t0, 8'd3, 16'h8000, 8'd7);
    send_item(OP_START_BEEPS, t0, '0, '0, '0);
    // melody armed while the burst runs
    send_item(OP_START_MEL, t0, '0, '0, '0);
    send_item(OP_TICK, t0, '0, '0, '0);
    send_item(OP_LOAD_NOTE + 3'd1, t0 + 32'd2, '0, '0, '0);
    send_item(OP_LOAD_NOTE + 3'd2, t0 + 32'd5, '0, '0, '0);
    // deadline crosses the wrap of the millisecond counter
    send_item(OP_LOAD_NOTE + 3'd3, t0 + 32'd8, '0, '0, '0);
    send_item(OP_TICK, t0 + 32'd13, '0, '0, '0);
    send_item(OP_TICK, t0 + 32'd16, '0, '0, '0);
    send_item(OP_TICK, t0 + 32'd16, '0, '0, '0);
    send_item(OP_TICK, t0 + 32'd1016, '0, '0, '0);
    send_item(OP_TICK, t0 + 32'd1019, '0, '0, '0);
    send_item(OP_TICK, t0 + 32'd1019 + 32'h8000_0005, '0, '0, '0);
    send_item(OP_TICK, t0 + 32'd2019, '0, '0, '0);
    send_item(OP_TICK, t0 + 32'd3019, '0, '0, '0);
    send_item(OP_STOP, t0 + 32'd3020, '0, '0, '0);
    send_item(OP_TICK, t0 + 32'd3021, '0, '0, '0);
    send_item(OP_LOAD_NOTE + 3'd3, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 8'hFF);
    send_item(OP_START_BEEPS, 32'hFFFF_FFFF, '0, '0, '0);
    send_item(OP_STOP, 32'h0000_0000, '0, '0, '0);
    drain();

    clock_ms = 32'd100;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) begin
        cnt = '1; bfreq = '1; on = '0; off = '0; len = LEN_W'(NOTE_DEPTH);
      end else if (ph == 1) begin
        cnt = '0; bfreq = '0; on = '1; off = '1; len = '0;
      end else begin
        r = $urandom_range(0, 9);
        cnt = (r < 6) ? CNT_W'($urandom_range(0, 4)) : (r < 8) ? CNT_W'($urandom) : '1;
        bfreq = rand_freq();
        r = $urandom_range(0, 9);
        on = (r < 7) ? MS_W'($urandom_range(0, 30)) : MS_W'($urandom);
        r = $urandom_range(0, 9);
        off = (r < 7) ? MS_W'($urandom_range(0, 30)) : MS_W'($urandom);
        r = $urandom_range(0, 9);
        len = (r < 6) ? LEN_W'($urandom_range(0, 10)) :
              (r < 8) ? LEN_W'($urandom_range(0, NOTE_DEPTH)) : LEN_W'(NOTE_DEPTH);
      end
      if (ph % 3 == 2) clock_ms = 32'hFFFF_FFFF - NOW_W'($urandom_range(0, 3000));
      program_registers(cnt, bfreq, on, off, len);
      load_melody(len);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long receiver hold-off while the sender keeps offering transactions
        if ((ph == 2 && n == 30) || (ph == 5 && n == 60)) hold_req = 1'b1;
        clock_ms = clock_ms + step_ms();
        r = $urandom_range(0, 99);
        if (r < 68)      op = OP_TICK;
        else if (r < 74) op = OP_START_BEEPS;
        else if (r < 80) op = OP_START_MEL;
        else if (r < 83) op = OP_STOP;
        else if (r < 92) op = OP_LOAD_NOTE;
        else             op = OP_LOAD_NOTE + OP_W'($urandom_range(1, 3));
        send_item(op, clock_ms, IDX_W'($urandom), rand_freq(), rand_div());
      end
      drain();
    end

    repeat (30) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
